FILE: hw/rtl/hrlp_pkg.sv
`default_nettype none

package hrlp_pkg;

	localparam int PATH_CAPACITY = 255;
	localparam int PCOUNT_W      = $clog2(PATH_CAPACITY + 1);
	localparam int PLEN_W        = (PCOUNT_W > 8) ? PCOUNT_W : 8;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [1:0] KIND_PATH   = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam logic [1:0] ERR_METHOD  = 2'd0;
	localparam logic [1:0] ERR_PATH    = 2'd1;
	localparam logic [1:0] ERR_VERSION = 2'd2;

	localparam logic [3:0] M_CONNECT = 4'd0;
	localparam logic [3:0] M_DELETE  = 4'd1;
	localparam logic [3:0] M_GET     = 4'd2;
	localparam logic [3:0] M_HEAD    = 4'd3;
	localparam logic [3:0] M_OPTIONS = 4'd4;
	localparam logic [3:0] M_PATCH   = 4'd5;
	localparam logic [3:0] M_POST    = 4'd6;
	localparam logic [3:0] M_PUT     = 4'd7;
	localparam logic [3:0] M_TRACE   = 4'd8;
	localparam int         N_METHODS = 9;

	localparam logic [2:0] MAX_LETTERS = 3'd7;
	localparam logic [2:0] PREFIX_LAST = 3'd4;

	typedef enum logic [6:0] {
		PH_METHOD    = 7'b0000001,
		PH_PATH_SKIP = 7'b0000010,
		PH_PATH      = 7'b0000100,
		PH_PREFIX    = 7'b0001000,
		PH_MAJOR     = 7'b0010000,
		PH_MINOR     = 7'b0100000,
		PH_DONE      = 7'b1000000
	} phase_t;

	typedef struct packed {
		phase_t                phase;
		logic [55:0]           letters;
		logic [2:0]            lcount;
		logic [2:0]            ppos;
		logic [3:0]            method;
		logic [PCOUNT_W-1:0]   pcount;
		logic [7:0]            major;
		logic [7:0]            minor;
	} pstate_t;

	localparam pstate_t PSTATE_RESET = '{
		phase:   PH_METHOD,
		letters: '0,
		lcount:  '0,
		ppos:    '0,
		method:  '0,
		pcount:  '0,
		major:   '0,
		minor:   '0
	};

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] path_byte;
		logic [3:0] method;
		logic [7:0] major;
		logic [7:0] minor;
		logic [7:0] plen;
		logic [1:0] err;
	} result_t;

	function automatic logic [55:0] method_word(input logic [3:0] k);
		logic [55:0] w;
		unique case (k)
			M_CONNECT: w = 56'("CONNECT");
			M_DELETE:  w = 56'("DELETE");
			M_GET:     w = 56'("GET");
			M_HEAD:    w = 56'("HEAD");
			M_OPTIONS: w = 56'("OPTIONS");
			M_PATCH:   w = 56'("PATCH");
			M_POST:    w = 56'("POST");
			M_PUT:     w = 56'("PUT");
			M_TRACE:   w = 56'("TRACE");
			default:   w = '1;
		endcase
		return w;
	endfunction

	function automatic logic [2:0] method_len(input logic [3:0] k);
		logic [2:0] n;
		unique case (k) inside
			M_CONNECT, M_OPTIONS:        n = 3'd7;
			M_DELETE:                    n = 3'd6;
			M_PATCH, M_TRACE:            n = 3'd5;
			M_HEAD, M_POST:              n = 3'd4;
			M_GET, M_PUT:                n = 3'd3;
			default:                     n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd0:    ch = 8'h48; // H
			3'd1:    ch = 8'h54; // T
			3'd2:    ch = 8'h54; // T
			3'd3:    ch = 8'h50; // P
			3'd4:    ch = 8'h2F; // /
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// v*10 + d, clamped to 255
	function automatic logic [7:0] add_digit(input logic [7:0] v, input logic [3:0] d);
		logic [11:0] r;
		r = ({4'd0, v} * 12'd10) + {8'd0, d};
		return (r > 12'd255) ? 8'hFF : r[7:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hrlp_step.sv
`default_nettype none

module hrlp_step (
	input  var hrlp_pkg::pstate_t cur,
	input  wire [7:0]             c,
	output hrlp_pkg::pstate_t     nxt,
	output logic                  res_valid,
	output hrlp_pkg::result_t     res
);
	import hrlp_pkg::*;

	logic              digit;
	logic              hit;
	logic [3:0]        hit_code;
	logic              rej;
	logic [1:0]        rej_err;
	logic              emit;
	logic              acc;
	logic [PLEN_W-1:0] pcount_ext;
	logic [7:0]        plen;

	assign digit = (c >= CH_ZERO) && (c <= CH_NINE);

	always_comb begin
		hit      = 1'b0;
		hit_code = '0;
		for (int k = 0; k < N_METHODS; k++) begin
			if (cur.lcount == method_len(4'(k)) && cur.letters == method_word(4'(k))) begin
				hit      = 1'b1;
				hit_code = 4'(k);
			end
		end
	end

	always_comb begin
		nxt     = cur;
		rej     = 1'b0;
		rej_err = ERR_METHOD;
		emit    = 1'b0;
		acc     = 1'b0;
		unique case (cur.phase)
			PH_METHOD: begin
				if (c == CH_SPACE) begin
					if (!hit) begin
						rej = 1'b1;
					end else begin
						nxt.method = hit_code;
						nxt.phase  = PH_PATH_SKIP;
					end
				end else if (c == CH_NUL || cur.lcount == MAX_LETTERS) begin
					rej = 1'b1;
				end else begin
					nxt.letters = {cur.letters[47:0], c};
					nxt.lcount  = cur.lcount + 3'd1;
				end
			end
			PH_PATH_SKIP: begin
				if (c == CH_NUL) begin
					rej     = 1'b1;
					rej_err = ERR_PATH;
				end else if (c != CH_SPACE) begin
					emit = 1'b1;
				end
			end
			PH_PATH: begin
				if (c == CH_SPACE) begin
					nxt.phase = PH_PREFIX;
					nxt.ppos  = '0;
				end else if (c == CH_NUL ||
				             PLEN_W'(cur.pcount) >= PLEN_W'(PATH_CAPACITY)) begin
					rej     = 1'b1;
					rej_err = ERR_PATH;
				end else begin
					emit = 1'b1;
				end
			end
			PH_PREFIX: begin
				if (cur.ppos == 3'd0 && c == CH_SPACE) begin
					// extra spaces ahead of the version
				end else if (cur.ppos > PREFIX_LAST || c != prefix_char(cur.ppos)) begin
					rej     = 1'b1;
					rej_err = ERR_VERSION;
				end else begin
					nxt.ppos = cur.ppos + 3'd1;
					if (cur.ppos == PREFIX_LAST) begin
						nxt.phase = PH_MAJOR;
					end
				end
			end
			PH_MAJOR: begin
				if (digit) begin
					nxt.major = add_digit(cur.major, c[3:0]);
				end else if (c == CH_DOT) begin
					nxt.phase = PH_MINOR;
				end else begin
					rej     = 1'b1;
					rej_err = ERR_VERSION;
				end
			end
			PH_MINOR: begin
				if (digit) begin
					nxt.minor = add_digit(cur.minor, c[3:0]);
				end else begin
					acc = 1'b1;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (emit) begin
			nxt.pcount = cur.pcount + PCOUNT_W'(1);
			nxt.phase  = PH_PATH;
		end
		if (rej || acc) begin
			nxt.phase = PH_DONE;
		end
	end

	assign pcount_ext = PLEN_W'(nxt.pcount);
	assign plen       = (pcount_ext > PLEN_W'(255)) ? 8'hFF : pcount_ext[7:0];

	always_comb begin
		res           = '0;
		res.plen      = plen;
		res.method    = cur.method;
		res_valid     = emit || rej || acc;
		if (emit) begin
			res.kind      = KIND_PATH;
			res.path_byte = c;
		end else if (acc) begin
			res.kind  = KIND_ACCEPT;
			res.major = cur.major;
			res.minor = cur.minor;
		end else begin
			res.kind = KIND_REJECT;
			res.err  = rej_err;
			// no method known yet while letters are still being collected
			if (cur.phase == PH_METHOD) begin
				res.method = '0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/http_request_line_parser_unit.sv
`default_nettype none

// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata = char_byte, tlast = last_byte
// m_*      out  m_tvalid/m_tready  tuser = result_kind, tdata = path..error fields
//
// One byte per cycle while the result register is not stalled; a taken byte goes to the
// input register, then through the one-pass parse step into the result register (m_tvalid).
// The last byte of a text runs the step a second time with a NUL to close the request,
// all in the same cycle, and the parse state returns to its reset value.
// Reset clears the state and both valid flags; no clearing pass.
// A stalled result register stops the input register, which then holds s_tready low.
module http_request_line_parser_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] char_byte
	input  wire         s_tlast,   // last_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [7:0] path_byte, [11:8] method_code,
	                               // [19:12] version_major, [27:20] version_minor,
	                               // [35:28] path_length, [37:36] error_code, rest zero
	output logic [1:0]  m_tuser    // [1:0] result_kind
);
	import hrlp_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	pstate_t    state_q;
	logic       out_valid_q;
	result_t    out_q;

	pstate_t    nxt_a;
	pstate_t    nxt_b;
	logic       va;
	logic       vb;
	result_t    ra;
	result_t    rb;

	pstate_t    state_d;
	logic       res_v;
	result_t    res_d;
	logic       advance;

	hrlp_step u_step_byte (
		.cur       (state_q),
		.c         (char_s1),
		.nxt       (nxt_a),
		.res_valid (va),
		.res       (ra)
	);

	// end-of-text close: same step fed a NUL
	hrlp_step u_step_close (
		.cur       (nxt_a),
		.c         (CH_NUL),
		.nxt       (nxt_b),
		.res_valid (vb),
		.res       (rb)
	);

	always_comb begin
		state_d = nxt_a;
		res_v   = va;
		res_d   = ra;
		if (last_s1) begin
			state_d = PSTATE_RESET;
			if (nxt_a.phase != PH_DONE && vb) begin
				res_v = 1'b1;
				res_d = rb;
			end
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= PSTATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				state_q <= state_d;
			end
			if (advance && res_v) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (advance && res_v) begin
			out_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {2'b00, out_q.err, out_q.plen, out_q.minor, out_q.major,
	                   out_q.method, out_q.path_byte};

endmodule

`default_nettype wire

FILE: tb/http_request_line_parser_unit_test.sv
module http_request_line_parser_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hrlp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [7:0] chr;
		bit         fin;
		bit         drain;
	} text_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	text_byte_t byte_reqs[$];
	result_t    expected_results[$];
	bit         hold_next;

	int errors;
	int cycles;
	int bytes_sent;
	int lines_sent;
	int accepts_seen;
	int rejects_seen;
	int path_bytes_seen;
	logic no_gaps;

	string      method_names [9] = '{"CONNECT", "DELETE", "GET", "HEAD", "OPTIONS",
	                                 "PATCH", "POST", "PUT", "TRACE"};
	logic [3:0] method_ids [9] = '{M_CONNECT, M_DELETE, M_GET, M_HEAD, M_OPTIONS,
	                               M_PATCH, M_POST, M_PUT, M_TRACE};
	string      http_tag = "HTTP/";

	// parser shadow state
	phase_t      line_phase;
	logic [55:0] letters;
	int          letter_cnt;
	int          prefix_pos;
	logic [3:0]  method_id;
	int          path_cnt;
	logic [7:0]  major_val;
	logic [7:0]  minor_val;

	http_request_line_parser_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// both sides run without gaps for a stretch in the middle of the run
	assign no_gaps = (bytes_sent >= 700) && (bytes_sent < 1000);

	function void clear_parser();
		line_phase = PH_METHOD;
		letters    = '0;
		letter_cnt = 0;
		prefix_pos = 0;
		method_id  = '0;
		path_cnt   = 0;
		major_val  = '0;
		minor_val  = '0;
	endfunction

	function logic [7:0] dec_sat(input logic [7:0] v, input logic [7:0] c);
		int t;
		t = int'(v) * 10 + int'(c - CH_ZERO);
		return (t > 255) ? 8'hFF : 8'(t);
	endfunction

	function logic [7:0] path_len_sat();
		return (path_cnt > 255) ? 8'hFF : 8'(path_cnt);
	endfunction

	function bit parse_char(input logic [7:0] c, output result_t r);
		bit          bad;
		bit          emit;
		bit          digit;
		logic [1:0]  err;
		int          hit;
		logic [55:0] word;
		bad   = 1'b0;
		emit  = 1'b0;
		err   = ERR_METHOD;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		r     = '0;
		case (line_phase) inside
			PH_METHOD: begin
				if (c == CH_SPACE) begin
					hit = -1;
					for (int k = 0; k < N_METHODS; k++) begin
						word = '0;
						for (int i = 0; i < method_names[k].len(); i++)
							word = {word[47:0], method_names[k][i]};
						if (letter_cnt == method_names[k].len() && word == letters)
							hit = k;
					end
					if (letter_cnt == 0 || hit < 0) begin
						bad = 1'b1;
					end else begin
						method_id  = method_ids[hit];
						line_phase = PH_PATH_SKIP;
					end
				end else if (c == CH_NUL || letter_cnt >= MAX_LETTERS) begin
					bad = 1'b1;
				end else begin
					letters = {letters[47:0], c};
					letter_cnt++;
				end
			end
			PH_PATH_SKIP, PH_PATH: begin
				if (c == CH_SPACE) begin
					if (line_phase == PH_PATH) begin
						line_phase = PH_PREFIX;
						prefix_pos = 0;
					end
				end else if (c == CH_NUL || path_cnt >= PATH_CAPACITY) begin
					bad = 1'b1;
					err = ERR_PATH;
				end else begin
					path_cnt++;
					line_phase  = PH_PATH;
					r.kind      = KIND_PATH;
					r.path_byte = c;
					r.method    = method_id;
					r.plen      = path_len_sat();
					emit        = 1'b1;
				end
			end
			PH_PREFIX: begin
				if (!(prefix_pos == 0 && c == CH_SPACE)) begin
					if (c != http_tag[prefix_pos]) begin
						bad = 1'b1;
						err = ERR_VERSION;
					end else begin
						prefix_pos++;
						if (prefix_pos == 5)
							line_phase = PH_MAJOR;
					end
				end
			end
			PH_MAJOR: begin
				if (digit) begin
					major_val = dec_sat(major_val, c);
				end else if (c == CH_DOT) begin
					line_phase = PH_MINOR;
				end else begin
					bad = 1'b1;
					err = ERR_VERSION;
				end
			end
			PH_MINOR: begin
				if (digit) begin
					minor_val = dec_sat(minor_val, c);
				end else begin
					r.kind     = KIND_ACCEPT;
					r.method   = method_id;
					r.major    = major_val;
					r.minor    = minor_val;
					r.plen     = path_len_sat();
					line_phase = PH_DONE;
					emit       = 1'b1;
				end
			end
			default: ;
		endcase
		if (bad) begin
			r.kind     = KIND_REJECT;
			r.method   = (line_phase == PH_METHOD) ? 4'd0 : method_id;
			r.plen     = path_len_sat();
			r.err      = err;
			line_phase = PH_DONE;
			emit       = 1'b1;
		end
		return emit;
	endfunction

	// end of text closes an open request as if a NUL followed
	function void predict_byte(input logic [7:0] c, input bit fin);
		result_t r;
		result_t closing;
		bit      got;
		got = parse_char(c, r);
		if (fin) begin
			if (line_phase != PH_DONE && parse_char(CH_NUL, closing)) begin
				r   = closing;
				got = 1'b1;
			end
			clear_parser();
		end
		if (got)
			expected_results.push_back(r);
	endfunction

	task add_byte(input logic [7:0] c);
		byte_reqs.push_back('{chr: c, fin: 1'b0, drain: hold_next});
		hold_next = 1'b0;
	endtask

	task add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task close_line();
		byte_reqs[$].fin = 1'b1;
	endtask

	task add_line(input string s);
		add_text(s);
		close_line();
	endtask

	task add_path(input int n);
		for (int i = 0; i < n; i++)
			add_byte(8'($urandom_range(33, 126)));
	endtask

	task add_random_line();
		string m;
		string tag;
		int    n;
		m = method_names[$urandom_range(0, 8)];
		if ($urandom_range(0, 9) == 0)
			m.putc($urandom_range(0, m.len() - 1), byte'($urandom_range(0, 255)));
		add_text(m);
		n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
		repeat (n) add_byte(CH_SPACE);
		n = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 258) : $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) == 0)
				add_byte(8'($urandom_range(0, 255)));
			else if ($urandom_range(0, 9) < 7)
				add_byte(8'($urandom_range(33, 126)));
			else
				add_byte(8'($urandom_range(1, 255)));
		end
		repeat ($urandom_range(1, 2)) add_byte(CH_SPACE);
		tag = http_tag;
		if ($urandom_range(0, 9) == 0)
			tag.putc($urandom_range(0, 4), byte'($urandom_range(0, 255)));
		add_text(tag);
		repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
		add_byte(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : CH_DOT);
		repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
		n = $urandom_range(0, 9);
		if (n < 5)
			add_byte(8'h0D);
		else if (n < 7)
			add_byte(8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 3)) add_byte(8'h0A);
		close_line();
	endtask

	task check_field(input string name, input int want, input int seen);
		if (want != seen) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, seen);
			errors++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			gap = !no_gaps && ($urandom_range(0, 99) < 35);
			if (s_tvalid && s_tready) begin
				predict_byte(s_tdata, s_tlast);
				if (s_tlast)
					lines_sent++;
				void'(byte_reqs.pop_front());
				bytes_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (byte_reqs.size() != 0 && !gap &&
				    !(byte_reqs[0].drain && expected_results.size() != 0)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= byte_reqs[0].chr;
					s_tlast  <= byte_reqs[0].fin;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				case (m_tuser)
					KIND_PATH:   path_bytes_seen++;
					KIND_ACCEPT: accepts_seen++;
					default:     rejects_seen++;
				endcase
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: kind %0d data %h", m_tuser, m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("result_kind", want.kind, m_tuser);
					check_field("path_byte", want.path_byte, m_tdata[7:0]);
					check_field("method_code", want.method, m_tdata[11:8]);
					check_field("version_major", want.major, m_tdata[19:12]);
					check_field("version_minor", want.minor, m_tdata[27:20]);
					check_field("path_length", want.plen, m_tdata[35:28]);
					check_field("error_code", want.err, m_tdata[37:36]);
				end
			end
			m_tready <= no_gaps || ($urandom_range(0, 99) >= 35);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
			         cycles, expected_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		clear_parser();
		hold_next = 1'b0;

		// directed lines
		add_line("GET /index.html HTTP/1.1\r\n");
		add_line(" GET / HTTP/1.1");
		add_line("CONNECTX / HTTP/1.1");
		add_line("get / HTTP/1.0");
		add_line("CONNECT host:443 HTTP/1.1\r");
		add_line("DELETE  /item/7  HTTP/255.999\r");
		add_line("HEAD /h HTTP/1:1");
		add_line("OPTIONS * HTTP/1.0/");
		add_line("PATCH /p HTXP/1.1");
		add_line("POST /q HTTP/.\r");
		add_line("PUT /r HTTP/2.0\rtrailing bytes");
		add_line("TRACE /t HTTP/1.1");
		add_line("GET /open");
		add_line("GET");
		add_line("G");
		add_line("GET /x HTTP");
		add_text("GET /ab");
		add_byte(CH_NUL);
		add_line("cd HTTP/1.1");
		add_text("GET ");
		add_byte(CH_NUL);
		close_line();
		add_byte(CH_NUL);
		close_line();
		add_text("GET /");
		add_path(PATH_CAPACITY - 1);
		add_line(" HTTP/1.1\r");
		add_text("GET /");
		add_path(PATH_CAPACITY);
		add_line(" HTTP/1.1\r");
		add_line("GET /v HTTP/1.");

		hold_next = 1'b1;
		for (int n = 0; byte_reqs.size() < 1950; n++) begin
			if (n % 25 == 24)
				hold_next = 1'b1;
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
				close_line();
			end else begin
				add_random_line();
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_reqs.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes in %0d request lines over %0d cycles",
		         bytes_sent, lines_sent, cycles);
		$display("Checked %0d path bytes, %0d accepted and %0d rejected lines",
		         path_bytes_seen, accepts_seen, rejects_seen);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
